### rtl/vsfc_pkg.sv
// Shared constants and types for the gas sensor frame codec.
`timescale 1ns / 1ps

package vsfc_pkg;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 88;

  localparam logic [7:0] CMD_HIGH = 8'h26;
  localparam logic [7:0] CMD_LOW  = 8'h0F;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Humidity full scale in Q7.8 (100 percent).
  localparam logic [14:0] H_FULL = 15'd25600;
  // Temperature offset and span in Q8.8 (45 and 175 degrees).
  localparam logic signed [17:0] T_OFFSET = 18'sd11520;
  localparam logic [15:0] T_SPAN = 16'd44800;

  // ceil(2^30 / 100) and ceil(2^32 / 175): exact for the operand widths used.
  localparam logic [23:0] H_RECIP = 24'd10737419;
  localparam logic [24:0] T_RECIP = 25'd24542671;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_REPLY = 1'b1
  } kind_t;

  typedef struct packed {
    logic [15:0] humid;
    logic [15:0] temp;
  } ticks_t;

endpackage

### rtl/vsfc_crc8.sv
// CRC-8 (poly 0x31, init 0xFF, MSB first) over a two-byte word.
`timescale 1ns / 1ps

module vsfc_crc8
  import vsfc_pkg::*;
(
  input  logic [7:0] byte_hi,
  input  logic [7:0] byte_lo,
  output logic [7:0] crc
);

  logic [7:0] mid;

  always_comb begin
    logic [7:0] c;
    c = CRC_INIT ^ byte_hi;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    mid = c;
  end

  always_comb begin
    logic [7:0] c;
    c = mid ^ byte_lo;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    crc = c;
  end

endmodule

### rtl/vsfc_scale.sv
// Scaling of humidity and temperature readings to 16-bit sensor ticks.
`timescale 1ns / 1ps

module vsfc_scale
  import vsfc_pkg::*;
(
  input  logic [14:0]        humidity,
  input  logic signed [16:0] temperature,
  output ticks_t             ticks
);

  logic [14:0]        h_clamp;
  logic [30:0]        h_prod;
  logic [46:0]        h_quot;
  logic signed [17:0] t_shift;
  logic [15:0]        t_clamp;
  logic [31:0]        t_prod;
  logic [48:0]        t_quot;

  // Clamp at full scale: anything beyond saturates to 0xFFFF.
  assign h_clamp = (humidity > H_FULL) ? H_FULL : humidity;
  assign h_prod  = {h_clamp, 16'b0} - 31'(h_clamp);
  assign h_quot  = 47'(h_prod[30:8]) * 47'(H_RECIP);

  assign t_shift = 18'(temperature) + T_OFFSET;

  always_comb begin
    if (t_shift[17]) begin
      t_clamp = '0;
    end else if (t_shift[16:0] > 17'(T_SPAN)) begin
      t_clamp = T_SPAN;
    end else begin
      t_clamp = t_shift[15:0];
    end
  end

  assign t_prod = {t_clamp, 16'b0} - 32'(t_clamp);
  assign t_quot = 49'(t_prod[31:8]) * 49'(T_RECIP);

  assign ticks.humid = h_quot[45:30];
  assign ticks.temp  = t_quot[47:32];

endmodule

### rtl/voc_sensor_frame_codec.sv
// Top level: input register, tick scaling stage, CRC and frame output register.
// An accepted input beat moves through the input register, stage B and the output register in order.
// Throughput: one beat per cycle while the output is not stalled; the three stages advance together.
// A stalled output holds all stages; in_tready follows the output register.
// Reset (rst_n low, synchronous) clears all stage valid flags.
// Payload registers are not reset.
`timescale 1ns / 1ps

module voc_sensor_frame_codec
  import vsfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // humidity[14:0], temperature[31:15], reply_high[39:32], reply_low[47:40],
  // reply_check[55:48]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // command_high[7:0], command_low[15:8], humid_high[23:16], humid_low[31:24],
  // humid_check[39:32], temp_high[47:40], temp_low[55:48], temp_check[63:56],
  // voc_value[79:64], reply_ok[80], zero[87:81]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                  adv;
  logic                  a_valid_r;
  kind_t                 a_kind_r;
  logic [IN_DATA_W-1:0]  a_data_r;
  logic                  b_valid_r;
  kind_t                 b_kind_r;
  ticks_t                b_ticks_r;
  logic [7:0]            b_rhigh_r;
  logic [7:0]            b_rlow_r;
  logic [7:0]            b_rcheck_r;
  ticks_t                ticks;
  logic [7:0]            crc_h;
  logic [7:0]            crc_t;
  logic [7:0]            crc_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] out_data_nxt;

  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= in_tvalid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind_r   <= kind_t'(in_tuser);
      a_data_r   <= in_tdata;
      b_kind_r   <= a_kind_r;
      b_ticks_r  <= ticks;
      b_rhigh_r  <= a_data_r[39:32];
      b_rlow_r   <= a_data_r[47:40];
      b_rcheck_r <= a_data_r[55:48];
      out_data_r <= out_data_nxt;
    end
  end

  vsfc_scale u_scale (
    .humidity    (a_data_r[14:0]),
    .temperature ($signed(a_data_r[31:15])),
    .ticks       (ticks)
  );

  vsfc_crc8 u_crc_humid (
    .byte_hi (b_ticks_r.humid[15:8]),
    .byte_lo (b_ticks_r.humid[7:0]),
    .crc     (crc_h)
  );

  vsfc_crc8 u_crc_temp (
    .byte_hi (b_ticks_r.temp[15:8]),
    .byte_lo (b_ticks_r.temp[7:0]),
    .crc     (crc_t)
  );

  vsfc_crc8 u_crc_reply (
    .byte_hi (b_rhigh_r),
    .byte_lo (b_rlow_r),
    .crc     (crc_r)
  );

  always_comb begin
    out_data_nxt = '0;
    case (b_kind_r)
      KIND_FRAME: begin
        out_data_nxt[7:0]   = CMD_HIGH;
        out_data_nxt[15:8]  = CMD_LOW;
        out_data_nxt[23:16] = b_ticks_r.humid[15:8];
        out_data_nxt[31:24] = b_ticks_r.humid[7:0];
        out_data_nxt[39:32] = crc_h;
        out_data_nxt[47:40] = b_ticks_r.temp[15:8];
        out_data_nxt[55:48] = b_ticks_r.temp[7:0];
        out_data_nxt[63:56] = crc_t;
      end
      KIND_REPLY: begin
        out_data_nxt[79:64] = {b_rhigh_r, b_rlow_r};
        out_data_nxt[80]    = (crc_r == b_rcheck_r);
      end
      default: begin
        out_data_nxt = '0;
      end
    endcase
  end

  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && adv |=> b_valid_r)
    else $error("stage A beat lost");

  b_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && adv |=> out_valid_r)
    else $error("stage B beat lost");

  one_half_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[63:0] == '0 || out_data_r[80:64] == '0))
    else $error("frame and reply fields both set");

  cmd_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[63:0] != '0 |-> out_data_r[15:0] == {CMD_LOW, CMD_HIGH})
    else $error("frame without command word");

  reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !a_valid_r && !b_valid_r)
    else $error("valid flags not cleared by reset");

endmodule

### sim/voc_sensor_frame_codec_tb.sv
// Self-checking testbench for voc_sensor_frame_codec under random flow control.
`timescale 1ns / 1ps

module voc_sensor_frame_codec_tb;
  import vsfc_pkg::*;

  localparam int  CYCLE_LIMIT = 250000;
  localparam int  LONG_HOLD   = 400;
  localparam int  DRAIN_WAIT  = 20;

  typedef struct {
    kind_t              kind;
    logic [14:0]        humidity;
    logic signed [16:0] temperature;
    logic [7:0]         reply_high;
    logic [7:0]         reply_low;
    logic [7:0]         reply_check;
  } reading_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic        reply_ok;
    logic [15:0] voc_value;
    logic [7:0]  temp_check;
    logic [7:0]  temp_low;
    logic [7:0]  temp_high;
    logic [7:0]  humid_check;
    logic [7:0]  humid_low;
    logic [7:0]  humid_high;
    logic [7:0]  command_low;
    logic [7:0]  command_high;
  } frame_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  reading_t    pending_readings[$];
  frame_beat_t expected_frames[$];
  reading_t    offered_reading;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          frame_mismatches = 0;
  int          hold_left = 0;
  logic        hold_kick = 1'b0;
  int          cycle_count = 0;

  voc_sensor_frame_codec i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] crc8_pair(logic [7:0] b0, logic [7:0] b1);
    logic [7:0]  crc;
    logic [15:0] msg;
    logic        fb;
    crc = 8'hFF;
    msg = {b0, b1};
    for (int i = 15; i >= 0; i--) begin
      fb  = crc[7] ^ msg[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? 8'h31 : 8'h00);
    end
    return crc;
  endfunction

  function automatic logic [15:0] humid_to_ticks(logic [14:0] h);
    longint q;
    q = (longint'(h) * 65535) / 25600;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic logic [15:0] temp_to_ticks(logic signed [16:0] t);
    longint shifted;
    longint q;
    shifted = longint'(t) + 11520;
    if (shifted <= 0) return 16'h0000;
    q = (shifted * 65535) / 44800;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  function automatic frame_beat_t predict_frame(reading_t r);
    frame_beat_t f;
    logic [15:0] hw;
    logic [15:0] tw;
    f = '0;
    if (r.kind == KIND_FRAME) begin
      hw = humid_to_ticks(r.humidity);
      tw = temp_to_ticks(r.temperature);
      f.command_high = 8'h26;
      f.command_low  = 8'h0F;
      f.humid_high   = hw[15:8];
      f.humid_low    = hw[7:0];
      f.humid_check  = crc8_pair(hw[15:8], hw[7:0]);
      f.temp_high    = tw[15:8];
      f.temp_low     = tw[7:0];
      f.temp_check   = crc8_pair(tw[15:8], tw[7:0]);
    end else begin
      f.voc_value = {r.reply_high, r.reply_low};
      f.reply_ok  = (crc8_pair(r.reply_high, r.reply_low) == r.reply_check);
    end
    return f;
  endfunction

  task automatic report_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      frame_mismatches++;
    end
  endtask

  task automatic compare_frame(frame_beat_t e, frame_beat_t a);
    report_field("command_high", e.command_high, a.command_high);
    report_field("command_low", e.command_low, a.command_low);
    report_field("humid_high", e.humid_high, a.humid_high);
    report_field("humid_low", e.humid_low, a.humid_low);
    report_field("humid_check", e.humid_check, a.humid_check);
    report_field("temp_high", e.temp_high, a.temp_high);
    report_field("temp_low", e.temp_low, a.temp_low);
    report_field("temp_check", e.temp_check, a.temp_check);
    report_field("voc_value", e.voc_value, a.voc_value);
    report_field("reply_ok", e.reply_ok, a.reply_ok);
    report_field("pad", e.pad, a.pad);
  endtask

  // Driver: hold a beat until accepted, then offer the next one or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_frames.push_back(predict_frame(offered_reading));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_reading = pending_readings.pop_front();
          in_tdata  <= {offered_reading.reply_check, offered_reading.reply_low,
                        offered_reading.reply_high, offered_reading.temperature,
                        offered_reading.humidity};
          in_tuser  <= offered_reading.kind;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_kick) begin
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check each accepted output beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual %h", $time, out_tdata);
          frame_mismatches++;
        end else begin
          compare_frame(expected_frames.pop_front(), frame_beat_t'(out_tdata));
        end
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_reading(kind_t k, logic [14:0] h, logic signed [16:0] t,
                             logic [7:0] rh, logic [7:0] rl, logic [7:0] rc);
    reading_t r;
    r.kind        = k;
    r.humidity    = h;
    r.temperature = t;
    r.reply_high  = rh;
    r.reply_low   = rl;
    r.reply_check = rc;
    pending_readings.push_back(r);
  endtask

  task automatic add_random(int count);
    logic [14:0]        h;
    logic signed [16:0] t;
    logic [7:0]         rh;
    logic [7:0]         rl;
    logic [7:0]         rc;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 80) begin
        h = 15'($urandom_range(25600));
        t = 17'(int'($urandom_range(44800)) - 11520);
      end else begin
        h = 15'($urandom);
        t = 17'($urandom);
      end
      rh = 8'($urandom);
      rl = 8'($urandom);
      rc = ($urandom_range(1) == 0) ? crc8_pair(rh, rl) : 8'($urandom);
      add_reading(($urandom_range(1) == 0) ? KIND_FRAME : KIND_REPLY, h, t, rh, rl, rc);
    end
  endtask

  task automatic drain();
    while (pending_readings.size() != 0 || in_tvalid || expected_frames.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_reading(KIND_FRAME, 15'd0, -17'sd11520, 8'h00, 8'h00, 8'h00);
    add_reading(KIND_FRAME, 15'd25600, 17'sd33280, 8'hFF, 8'hFF, 8'hFF);
    add_reading(KIND_FRAME, 15'd25599, -17'sd11519, 8'h12, 8'h34, 8'h56);
    add_reading(KIND_FRAME, 15'd1, 17'sd33279, 8'h00, 8'h00, 8'h00);
    add_reading(KIND_FRAME, 15'd25601, 17'sd33281, 8'h00, 8'h00, 8'h00);
    add_reading(KIND_FRAME, 15'h7FFF, 17'sd65535, 8'hAA, 8'h55, 8'hA5);
    add_reading(KIND_FRAME, 15'd12800, -17'sd65536, 8'h00, 8'h00, 8'h00);
    add_reading(KIND_FRAME, 15'd100, -17'sd11521, 8'h00, 8'h00, 8'h00);
    add_reading(KIND_FRAME, 15'd6400, 17'sd0, 8'h00, 8'h00, 8'h00);
    add_reading(KIND_FRAME, 15'd19200, -17'sd1, 8'h00, 8'h00, 8'h00);
    add_reading(KIND_REPLY, 15'h7FFF, -17'sd1, 8'hBE, 8'hEF, crc8_pair(8'hBE, 8'hEF));
    add_reading(KIND_REPLY, 15'd0, 17'sd0, 8'hBE, 8'hEF, crc8_pair(8'hBE, 8'hEF) ^ 8'h01);
    add_reading(KIND_REPLY, 15'd0, 17'sd0, 8'h00, 8'h00, crc8_pair(8'h00, 8'h00));
    add_reading(KIND_REPLY, 15'd0, 17'sd0, 8'hFF, 8'hFF, crc8_pair(8'hFF, 8'hFF));
    add_reading(KIND_REPLY, 15'd0, 17'sd0, 8'hFF, 8'hFF, 8'h00);
    add_reading(KIND_REPLY, 15'd0, 17'sd0, 8'h00, 8'h00, 8'hFF);
    add_reading(KIND_REPLY, 15'd0, 17'sd0, 8'h80, 8'h01, crc8_pair(8'h80, 8'h01));
    add_reading(KIND_REPLY, 15'd0, 17'sd0, 8'h01, 8'h80, 8'h80);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random(420);
    drain();

    send_idle_pct  = 56;
    recv_stall_pct = 0;
    add_random(420);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 56;
    add_random(420);
    drain();

    send_idle_pct  = 30;
    recv_stall_pct = 30;
    add_random(420);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_kick = 1'b1;
    @(negedge clk);
    hold_kick = 1'b0;
    add_random(60);
    drain();

    repeat (DRAIN_WAIT) @(negedge clk);
    if (frame_mismatches == 0 && expected_frames.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
